// ===== rtl/axrot_pkg.sv =====
`default_nettype none
package axrot_pkg;

  localparam int DEG_HALF_TURN = 180;
  localparam int ANG_UNITS_PER_DEG = 64;
  localparam int ANG_FULL = 2 * DEG_HALF_TURN * ANG_UNITS_PER_DEG;
  localparam int ANG_QUARTER = ANG_FULL / 4;
  localparam int ANG_EIGHTH = ANG_FULL / 8;
  localparam logic [20:0] RAD_PER_UNIT_Q32 = 21'd1171271;
  localparam int ONE_Q14 = 16384;

  // pipeline shape
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS = 16;
  localparam int TRIG_LAT = 14;
  localparam int NORM_LAT = 4 + SQRT_STEPS + DIV_STEPS;
  localparam int MAT_LAT = 3;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } axrot_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } axrot_out_t;

  // unit axis handed from the normaliser to the matrix stage
  typedef struct packed {
    logic zero;
    q14_t ux;
    q14_t uy;
    q14_t uz;
  } axrot_unit_t;

endpackage
`default_nettype wire

// ===== rtl/axrot_trig.sv =====
`default_nettype none
module axrot_trig (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic signed [15:0] angle,
  output logic               out_vld,
  output axrot_pkg::q14_t    s,
  output axrot_pkg::q14_t    c
);
  import axrot_pkg::*;

  localparam logic [15:0] DIVS [1:7] = '{16'd2, 16'd6, 16'd24, 16'd120, 16'd720,
                                         16'd5040, 16'd40320};
  localparam logic [31:0] RECIP [1:7] = '{
    32'((64'd1 << 32) / 64'd2),    32'((64'd1 << 32) / 64'd6),
    32'((64'd1 << 32) / 64'd24),   32'((64'd1 << 32) / 64'd120),
    32'((64'd1 << 32) / 64'd720),  32'((64'd1 << 32) / 64'd5040),
    32'((64'd1 << 32) / 64'd40320)};

  // wrap into one turn
  logic signed [16:0] a_ext, a_lo, a_hi;
  logic [14:0] a_wrap;
  logic [14:0] a0;
  logic v0;

  always_comb begin
    a_ext = 17'(angle);
    a_lo = a_ext + 17'(ANG_FULL);
    a_hi = a_ext - 17'(ANG_FULL);
    if (a_ext < 0) begin
      a_wrap = (a_lo < 0) ? 15'(a_lo + 17'(ANG_FULL)) : 15'(a_lo);
    end else if (a_ext >= 17'(ANG_FULL)) begin
      a_wrap = 15'(a_hi);
    end else begin
      a_wrap = 15'(a_ext);
    end
  end

  // quadrant and octant fold
  logic [1:0] q_c;
  logic [12:0] r_c;
  logic [11:0] rr_c;
  logic sw_c;
  logic [1:0] q1;
  logic [11:0] rr1;
  logic sw1, v1;

  always_comb begin
    if (a0 >= 15'(3 * ANG_QUARTER)) begin
      q_c = 2'd3;
      r_c = 13'(a0 - 15'(3 * ANG_QUARTER));
    end else if (a0 >= 15'(2 * ANG_QUARTER)) begin
      q_c = 2'd2;
      r_c = 13'(a0 - 15'(2 * ANG_QUARTER));
    end else if (a0 >= 15'(ANG_QUARTER)) begin
      q_c = 2'd1;
      r_c = 13'(a0 - 15'(ANG_QUARTER));
    end else begin
      q_c = 2'd0;
      r_c = 13'(a0);
    end
    if (r_c <= 13'(ANG_EIGHTH)) begin
      rr_c = 12'(r_c);
      sw_c = 1'b0;
    end else begin
      rr_c = 12'(13'(ANG_QUARTER) - r_c);
      sw_c = 1'b1;
    end
  end

  // power ladder: pw[st][k] holds x^(k+1) once st >= k
  logic [29:0] pw [0:7][0:7];
  logic [1:0] pq [0:7];
  logic psw [0:7];
  logic pv [0:7];

  // reciprocal estimate, correction, sum, fold
  logic [29:0] xe, pe [1:7], qe [1:7];
  logic [29:0] xc, qc [1:7];
  logic [1:0] qdE, qdC, qdS;
  logic swE, swC, swS, vE, vC, vS;
  logic [45:0] crem [1:7];
  logic signed [32:0] sv, cv;
  logic [14:0] s0, c0;

  always_comb begin
    for (int k = 1; k < 8; k++) begin
      crem[k] = 46'(pe[k]) - 46'(qe[k]) * 46'(DIVS[k]);
    end
    sv = 33'(xc) - 33'(qc[2]) + 33'(qc[4]) - 33'(qc[6]);
    cv = (33'd1 << 30) - 33'(qc[1]) + 33'(qc[3]) - 33'(qc[5]) + 33'(qc[7]);
  end

  logic [14:0] ss, cc;
  always_comb begin
    ss = swS ? c0 : s0;
    cc = swS ? s0 : c0;
  end

  always_ff @(posedge clk) begin
    a0 <= a_wrap;
    q1 <= q_c;
    rr1 <= rr_c;
    sw1 <= sw_c;
    for (int k = 0; k < 8; k++) begin
      pw[0][k] <= (k == 0) ?
        30'((33'(rr1) * 33'(RAD_PER_UNIT_Q32) + 33'd2) >> 2) : '0;
    end
    pq[0] <= q1;
    psw[0] <= sw1;
    for (int st = 1; st < 8; st++) begin
      for (int k = 0; k < 8; k++) begin
        if (k < st) begin
          pw[st][k] <= pw[st-1][k];
        end else if (k == st) begin
          pw[st][k] <= 30'((60'(pw[st-1][st-1]) * 60'(pw[st-1][0])) >> 30);
        end else begin
          pw[st][k] <= '0;
        end
      end
      pq[st] <= pq[st-1];
      psw[st] <= psw[st-1];
    end
    xe <= pw[7][0];
    for (int k = 1; k < 8; k++) begin
      pe[k] <= pw[7][k];
      qe[k] <= 30'((62'(pw[7][k]) * 62'(RECIP[k])) >> 32);
    end
    qdE <= pq[7];
    swE <= psw[7];
    xc <= xe;
    for (int k = 1; k < 8; k++) begin
      qc[k] <= (crem[k] >= 46'(DIVS[k])) ? qe[k] + 30'd1 : qe[k];
    end
    qdC <= qdE;
    swC <= swE;
    s0 <= sv[32] ? '0 : 15'((sv + 33'd32768) >> 16);
    c0 <= cv[32] ? '0 : 15'((cv + 33'd32768) >> 16);
    qdS <= qdC;
    swS <= swC;
    unique case (qdS)
      2'd0: begin s <= 16'({1'b0, ss});  c <= 16'({1'b0, cc});  end
      2'd1: begin s <= 16'({1'b0, cc});  c <= -16'({1'b0, ss}); end
      2'd2: begin s <= -16'({1'b0, ss}); c <= -16'({1'b0, cc}); end
      2'd3: begin s <= -16'({1'b0, cc}); c <= 16'({1'b0, ss});  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      for (int st = 0; st < 8; st++) pv[st] <= 1'b0;
      vE <= 1'b0;
      vC <= 1'b0;
      vS <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v0 <= in_vld;
      v1 <= v0;
      pv[0] <= v1;
      for (int st = 1; st < 8; st++) pv[st] <= pv[st-1];
      vE <= pv[7];
      vC <= vE;
      vS <= vC;
      out_vld <= vS;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/axrot_norm.sv =====
`default_nettype none
module axrot_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic signed [15:0]     axis_x,
  input  logic signed [15:0]     axis_y,
  input  logic signed [15:0]     axis_z,
  output logic                   out_vld,
  output axrot_pkg::axrot_unit_t unit
);
  import axrot_pkg::*;

  logic signed [15:0] vin [0:2];
  assign vin[0] = axis_x;
  assign vin[1] = axis_y;
  assign vin[2] = axis_z;

  // squares, magnitudes
  logic [30:0] sq [0:2];
  logic [15:0] mag0 [0:2];
  logic [2:0] neg0;
  logic zero0, v0;

  // sqrt pipe, stage 0 is the loaded radicand
  logic [61:0] rad [0:SQRT_STEPS];
  logic [32:0] rem [0:SQRT_STEPS];
  logic [30:0] root [0:SQRT_STEPS];
  logic [15:0] smag [0:SQRT_STEPS][0:2];
  logic [2:0] sneg [0:SQRT_STEPS];
  logic szero [0:SQRT_STEPS];
  logic sv [0:SQRT_STEPS];
  logic [34:0] rsh [1:SQRT_STEPS];
  logic [34:0] trial [1:SQRT_STEPS];

  // divide pipe, stage 0 is the loaded dividend
  logic [30:0] dvr [0:DIV_STEPS];
  logic [45:0] drem [0:DIV_STEPS][0:2];
  logic [15:0] quo [0:DIV_STEPS][0:2];
  logic [2:0] dneg [0:DIV_STEPS];
  logic dzero [0:DIV_STEPS];
  logic dv [0:DIV_STEPS];
  logic [46:0] dsub [1:DIV_STEPS];

  always_comb begin
    for (int st = 1; st <= SQRT_STEPS; st++) begin
      rsh[st] = {rem[st-1], rad[st-1][61:60]};
      trial[st] = {2'b00, root[st-1], 2'b01};
    end
    for (int st = 1; st <= DIV_STEPS; st++) begin
      dsub[st] = 47'(dvr[st-1]) << (DIV_STEPS - st);
    end
  end

  logic [15:0] qclamp [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qclamp[i] = (quo[DIV_STEPS][i] > 16'(ONE_Q14)) ? 16'(ONE_Q14) : quo[DIV_STEPS][i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= 31'(32'(vin[i]) * 32'(vin[i]));
      mag0[i] <= 16'(vin[i] < 0 ? -17'(vin[i]) : 17'(vin[i]));
      neg0[i] <= vin[i][15];
    end
    zero0 <= (axis_x == 0) && (axis_y == 0) && (axis_z == 0);

    rad[0] <= {32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]), 30'd0};
    rem[0] <= '0;
    root[0] <= '0;
    smag[0] <= mag0;
    sneg[0] <= neg0;
    szero[0] <= zero0;
    for (int st = 1; st <= SQRT_STEPS; st++) begin
      if (rsh[st] >= trial[st]) begin
        rem[st] <= 33'(rsh[st] - trial[st]);
        root[st] <= {root[st-1][29:0], 1'b1};
      end else begin
        rem[st] <= rsh[st][32:0];
        root[st] <= {root[st-1][29:0], 1'b0};
      end
      rad[st] <= rad[st-1] << 2;
      smag[st] <= smag[st-1];
      sneg[st] <= sneg[st-1];
      szero[st] <= szero[st-1];
    end

    dvr[0] <= root[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      drem[0][i] <= {1'b0, smag[SQRT_STEPS][i], 29'd0} + 46'(root[SQRT_STEPS] >> 1);
      quo[0][i] <= '0;
    end
    dneg[0] <= sneg[SQRT_STEPS];
    dzero[0] <= szero[SQRT_STEPS];
    for (int st = 1; st <= DIV_STEPS; st++) begin
      for (int i = 0; i < 3; i++) begin
        if (47'(drem[st-1][i]) >= dsub[st]) begin
          drem[st][i] <= 46'(47'(drem[st-1][i]) - dsub[st]);
          quo[st][i] <= {quo[st-1][i][14:0], 1'b1};
        end else begin
          drem[st][i] <= drem[st-1][i];
          quo[st][i] <= {quo[st-1][i][14:0], 1'b0};
        end
      end
      dvr[st] <= dvr[st-1];
      dneg[st] <= dneg[st-1];
      dzero[st] <= dzero[st-1];
    end

    unit.zero <= dzero[DIV_STEPS];
    unit.ux <= dneg[DIV_STEPS][0] ? -qclamp[0] : qclamp[0];
    unit.uy <= dneg[DIV_STEPS][1] ? -qclamp[1] : qclamp[1];
    unit.uz <= dneg[DIV_STEPS][2] ? -qclamp[2] : qclamp[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      for (int st = 0; st <= SQRT_STEPS; st++) sv[st] <= 1'b0;
      for (int st = 0; st <= DIV_STEPS; st++) dv[st] <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v0 <= in_vld;
      sv[0] <= v0;
      for (int st = 1; st <= SQRT_STEPS; st++) sv[st] <= sv[st-1];
      dv[0] <= sv[SQRT_STEPS];
      for (int st = 1; st <= DIV_STEPS; st++) dv[st] <= dv[st-1];
      out_vld <= dv[DIV_STEPS];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/axrot_mat.sv =====
`default_nettype none
module axrot_mat (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  axrot_pkg::q14_t        s,
  input  axrot_pkg::q14_t        c,
  input  axrot_pkg::axrot_unit_t unit,
  output logic                   out_vld,
  output axrot_pkg::axrot_out_t  result
);
  import axrot_pkg::*;

  logic signed [15:0] u [0:2];
  assign u[0] = unit.ux;
  assign u[1] = unit.uy;
  assign u[2] = unit.uz;

  // stage A: products of the axis and of the sine
  logic signed [29:0] uu [0:2][0:2];
  logic signed [30:0] suA [0:2];
  logic signed [17:0] omc;
  logic signed [15:0] cA;
  logic zA, vA;

  // stage B: weighted outer product
  logic signed [47:0] t [0:2][0:2];
  logic signed [30:0] suB [0:2];
  logic signed [15:0] cB;
  logic zB, vB;

  logic signed [47:0] skew [0:2][0:2];
  logic signed [47:0] e [0:2][0:2];
  logic signed [47:0] rv [0:2][0:2];
  logic signed [15:0] ent [0:2][0:2];

  always_comb begin
    skew[0][0] = '0;
    skew[0][1] = -48'(suB[2]);
    skew[0][2] = 48'(suB[1]);
    skew[1][0] = 48'(suB[2]);
    skew[1][1] = '0;
    skew[1][2] = -48'(suB[0]);
    skew[2][0] = -48'(suB[1]);
    skew[2][1] = 48'(suB[0]);
    skew[2][2] = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = t[i][j] + (skew[i][j] <<< 14) + ((i == j) ? (48'(cB) <<< 28) : 48'sd0);
        rv[i][j] = (e[i][j] + 48'sd134217728) >>> 28;
        if (zB) begin
          ent[i][j] = (i == j) ? 16'(ONE_Q14) : 16'sd0;
        end else if (rv[i][j] > 48'(ONE_Q14)) begin
          ent[i][j] = 16'(ONE_Q14);
        end else if (rv[i][j] < -48'(ONE_Q14)) begin
          ent[i][j] = -16'(ONE_Q14);
        end else begin
          ent[i][j] = 16'(rv[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        uu[i][j] <= 30'(30'(u[i]) * 30'(u[j]));
        t[i][j] <= 48'(omc) * 48'(uu[i][j]);
      end
      suA[i] <= 31'(s) * 31'(u[i]);
      suB[i] <= suA[i];
    end
    omc <= 18'(ONE_Q14) - 18'(c);
    cA <= c;
    zA <= unit.zero;
    cB <= cA;
    zB <= zA;
    result.m00 <= ent[0][0];
    result.m01 <= ent[0][1];
    result.m02 <= ent[0][2];
    result.m10 <= ent[1][0];
    result.m11 <= ent[1][1];
    result.m12 <= ent[1][2];
    result.m20 <= ent[2][0];
    result.m21 <= ent[2][1];
    result.m22 <= ent[2][2];
    result.zero_axis <= zB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
      vB <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vA <= in_vld;
      vB <= vA;
      out_vld <= vB;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
`default_nettype none
// The path from an accepted start to its done strobe is set mainly by the
// 31-stage square root and the 16-stage divider of the axis normaliser.
// Throughput: one word per cycle; busy is held low and every start is taken.
// The receiver cannot stall: each result shows for one cycle under done.
// Reset (rst, synchronous, active high) clears only the valid bits.
module axis_angle_rotation_matrix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  axrot_pkg::axrot_in_t  item,
  output logic                  done,
  output axrot_pkg::axrot_out_t result
);
  import axrot_pkg::*;

  // sine/cosine finish early; hold them until the unit axis catches up
  localparam int DLY = NORM_LAT - TRIG_LAT;
  localparam int TOTAL_LAT = NORM_LAT + MAT_LAT;

  logic trig_vld, norm_vld;
  q14_t s, c;
  axrot_unit_t unit;

  q14_t s_dly [0:DLY-1];
  q14_t c_dly [0:DLY-1];
  logic v_dly [0:DLY-1];

  // no back-pressure anywhere: accept every start
  assign busy = 1'b0;

  axrot_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start),
    .angle   (item.angle),
    .out_vld (trig_vld),
    .s       (s),
    .c       (c)
  );

  axrot_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start),
    .axis_x  (item.axis_x),
    .axis_y  (item.axis_y),
    .axis_z  (item.axis_z),
    .out_vld (norm_vld),
    .unit    (unit)
  );

  // advance the angle results down the alignment line
  always_ff @(posedge clk) begin
    s_dly[0] <= s;
    c_dly[0] <= c;
    for (int i = 1; i < DLY; i++) begin
      s_dly[i] <= s_dly[i-1];
      c_dly[i] <= c_dly[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) v_dly[i] <= 1'b0;
    end else begin
      v_dly[0] <= trig_vld;
      for (int i = 1; i < DLY; i++) v_dly[i] <= v_dly[i-1];
    end
  end

  axrot_mat u_mat (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (norm_vld),
    .s       (s_dly[DLY-1]),
    .c       (c_dly[DLY-1]),
    .unit    (unit),
    .out_vld (done),
    .result  (result)
  );

  // both halves of a word must meet at the matrix stage
  a_align: assert property (@(posedge clk) disable iff (rst)
    norm_vld == v_dly[DLY-1])
    else $error("angle and axis paths out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("done without a matching start");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_axis |->
      result.m00 == 16'sd16384 && result.m11 == 16'sd16384 && result.m22 == 16'sd16384 &&
      result.m01 == 16'sd0 && result.m02 == 16'sd0 && result.m10 == 16'sd0 &&
      result.m12 == 16'sd0 && result.m20 == 16'sd0 && result.m21 == 16'sd0)
    else $error("zero axis did not give the identity");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    norm_vld && !unit.zero |->
      unit.ux <= 16'sd16384 && unit.ux >= -16'sd16384 &&
      unit.uy <= 16'sd16384 && unit.uy >= -16'sd16384 &&
      unit.uz <= 16'sd16384 && unit.uz >= -16'sd16384)
    else $error("unit axis component out of range");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
  import axrot_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  axrot_in_t  item = '0;
  logic       done;
  axrot_out_t result;

  axis_angle_rotation_matrix dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always #1 clk = ~clk;

  // words waiting to go in, and matrices still owed by the block
  axrot_in_t  pending_words[$];
  axrot_out_t matrices_due[$];
  int         errs = 0;
  logic       took_word = 1'b0;
  int         gap_left = 0;
  bit         calm = 1'b0;      // no idling in the last part of the run
  bit         drain_hold = 1'b0;
  bit         drained_once = 1'b0;

  // Octant sine/cosine by truncated Taylor series, Q30 inside, Q14 out.
  function automatic void octant_trig(input int r, output int s, output int c);
    longint unsigned x, p2, p3, p4, p5, p6, p7, p8;
    longint sv, cv;
    x  = (longint'(r) * 64'd1171271 + 64'd2) >> 2;
    p2 = (x * x) >> 30;
    p3 = (p2 * x) >> 30;
    p4 = (p3 * x) >> 30;
    p5 = (p4 * x) >> 30;
    p6 = (p5 * x) >> 30;
    p7 = (p6 * x) >> 30;
    p8 = (p7 * x) >> 30;
    sv = longint'(x) - longint'(p3 / 6) + longint'(p5 / 120) - longint'(p7 / 5040);
    cv = (longint'(1) << 30) - longint'(p2 / 2) + longint'(p4 / 24)
         - longint'(p6 / 720) + longint'(p8 / 40320);
    if (sv < 0) sv = 0;
    if (cv < 0) cv = 0;
    s = int'((longint'(sv) + 32768) >>> 16);
    c = int'((longint'(cv) + 32768) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int unit_part(input int v, input longint unsigned len);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q   = ((mag << 29) + len / 2) / len;
    if (q > ONE_Q14) q = 64'(ONE_Q14);
    return (v < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic logic signed [15:0] round_entry(input longint e);
    longint v;
    v = (e + (longint'(1) << 27)) >>> 28;
    if (v > ONE_Q14) v = longint'(ONE_Q14);
    if (v < -ONE_Q14) v = -longint'(ONE_Q14);
    return v[15:0];
  endfunction

  // Expected rotation matrix for one word.
  function automatic axrot_out_t rotation_of(input axrot_in_t w);
    axrot_out_t o;
    int v[3], u[3], k[3][3], m[9];
    int a, q, r, s0, c0, s, c;
    longint unsigned n2, len;
    longint e;
    o = '0;
    v[0] = int'(w.axis_x); v[1] = int'(w.axis_y); v[2] = int'(w.axis_z);
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      o.m00 = 16'(ONE_Q14); o.m11 = 16'(ONE_Q14); o.m22 = 16'(ONE_Q14);
      o.zero_axis = 1'b1;
      return o;
    end
    n2  = longint'(v[0]) * v[0] + longint'(v[1]) * v[1] + longint'(v[2]) * v[2];
    len = int_sqrt(n2 << 30);
    for (int i = 0; i < 3; i++) u[i] = unit_part(v[i], len);
    a = int'(w.angle) % ANG_FULL;
    if (a < 0) a += ANG_FULL;
    q = a / ANG_QUARTER;
    r = a % ANG_QUARTER;
    if (r <= ANG_EIGHTH) octant_trig(r, s0, c0);
    else octant_trig(ANG_QUARTER - r, c0, s0);
    case (q)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
    k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
    k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
    k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = longint'(ONE_Q14 - c) * longint'(u[i]) * longint'(u[j]);
        e += longint'(s) * longint'(k[i][j]) * ONE_Q14;
        if (i == j) e += longint'(c) << 28;
        m[i*3+j] = int'(round_entry(e));
      end
    o.m00 = 16'(m[0]); o.m01 = 16'(m[1]); o.m02 = 16'(m[2]);
    o.m10 = 16'(m[3]); o.m11 = 16'(m[4]); o.m12 = 16'(m[5]);
    o.m20 = 16'(m[6]); o.m21 = 16'(m[7]); o.m22 = 16'(m[8]);
    o.zero_axis = 1'b0;
    return o;
  endfunction

  // Driver: advance the queue after a taken word, idle in bursts, hold for
  // a full drain once around the middle of the run.
  always @(negedge clk) begin
    if (took_word && pending_words.size() > 0) void'(pending_words.pop_front());
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (!drained_once && pending_words.size() == 200) begin
        drain_hold   = 1'b1;
        drained_once = 1'b1;
      end
      if (drain_hold && matrices_due.size() == 0 && !took_word) drain_hold = 1'b0;
      if (gap_left == 0 && !calm && $urandom_range(0, 7) == 0)
        gap_left = $urandom_range(1, 9);
      if (pending_words.size() == 0 || drain_hold || gap_left > 0) begin
        start <= 1'b0;
        item  <= axrot_in_t'({$urandom, $urandom});
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        item  <= pending_words[0];
      end
    end
  end

  // Monitor: record each taken word's matrix and check each done strobe.
  always @(posedge clk) begin
    axrot_out_t want;
    took_word <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) matrices_due.push_back(rotation_of(item));
      if (done) begin
        if (matrices_due.size() == 0) begin
          $error("unexpected result word %h", result);
          errs++;
        end else begin
          want = matrices_due.pop_front();
          if (result.m00 !== want.m00) begin $error("m00 exp %0d got %0d", want.m00, result.m00); errs++; end
          if (result.m01 !== want.m01) begin $error("m01 exp %0d got %0d", want.m01, result.m01); errs++; end
          if (result.m02 !== want.m02) begin $error("m02 exp %0d got %0d", want.m02, result.m02); errs++; end
          if (result.m10 !== want.m10) begin $error("m10 exp %0d got %0d", want.m10, result.m10); errs++; end
          if (result.m11 !== want.m11) begin $error("m11 exp %0d got %0d", want.m11, result.m11); errs++; end
          if (result.m12 !== want.m12) begin $error("m12 exp %0d got %0d", want.m12, result.m12); errs++; end
          if (result.m20 !== want.m20) begin $error("m20 exp %0d got %0d", want.m20, result.m20); errs++; end
          if (result.m21 !== want.m21) begin $error("m21 exp %0d got %0d", want.m21, result.m21); errs++; end
          if (result.m22 !== want.m22) begin $error("m22 exp %0d got %0d", want.m22, result.m22); errs++; end
          if (result.zero_axis !== want.zero_axis) begin
            $error("zero_axis exp %0d got %0d", want.zero_axis, result.zero_axis);
            errs++;
          end
        end
      end
    end
  end

  function automatic axrot_in_t word_of(int a, int x, int y, int z);
    axrot_in_t w;
    w.angle = 16'(a); w.axis_x = 16'(x); w.axis_y = 16'(y); w.axis_z = 16'(z);
    return w;
  endfunction

  initial begin
    int pick;
    axrot_in_t w;
    // directed: angle extremes and octant edges, zero axis, axis extremes
    pending_words.push_back(word_of(0, 16384, 0, 0));
    pending_words.push_back(word_of(32767, 0, 16384, 0));
    pending_words.push_back(word_of(-32768, 0, 0, 16384));
    pending_words.push_back(word_of(2880, 16384, 16384, 16384));
    pending_words.push_back(word_of(2881, -16384, 16384, 0));
    pending_words.push_back(word_of(5760, 0, 0, -32768));
    pending_words.push_back(word_of(11520, 32767, 32767, 32767));
    pending_words.push_back(word_of(17280, -32768, -32768, -32768));
    pending_words.push_back(word_of(23039, 1, 0, 0));
    pending_words.push_back(word_of(-1, 0, -1, 0));
    pending_words.push_back(word_of(-23040, 0, 0, 1));
    pending_words.push_back(word_of(1234, 0, 0, 0));
    pending_words.push_back(word_of(-32768, 0, 0, 0));
    pending_words.push_back(word_of(8640, -32768, 0, 0));
    pending_words.push_back(word_of(20160, 32767, -32768, 1));
    pending_words.push_back(word_of(5759, 1, 1, 1));
    pending_words.push_back(word_of(14400, -1, -1, -1));
    for (int n = 0; n < 400; n++) begin
      pick = $urandom_range(0, 9);
      w = axrot_in_t'({$urandom, $urandom});
      if (pick == 0) begin
        w.axis_x = 0; w.axis_y = 0; w.axis_z = 0;
      end else if (pick < 3) begin
        w.axis_x = 16'($signed($urandom_range(0, 63)) - 32);
        w.axis_y = 16'($signed($urandom_range(0, 63)) - 32);
        w.axis_z = 16'($signed($urandom_range(0, 63)) - 32);
      end else if (pick == 3) begin
        w.axis_y = 0; w.axis_z = 0;
      end
      pending_words.push_back(w);
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    wait (pending_words.size() < 60);
    calm = 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk);
    wait (matrices_due.size() == 0);
    repeat (80) @(posedge clk);
    if (errs == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
